@@ design/dics_pkg.sv @@
// dics_pkg: shared types and constants of the discrete inverse-cdf sampler
// used by dics_front, dics_back and discrete_inverse_cdf_sampler
package dics_pkg;

   localparam int MAX_ENTRIES_DEF   = 64;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int VALUE_W           = 32;
   localparam int STATUS_W          = 3;
   localparam int TOL_RESET         = 7;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_RANGE
   } cmd_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_RANGE   = 3'd2,
      ST_SUMFAIL = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
      logic         last;
   } cmd_ctl_type;

endpackage

@@ design/dics_front.sv @@
// dics_front: accepts transactions, classifies them and queues them for the back end
// depends on dics_pkg
module dics_front #(
   parameter int  FRACTION_BITS = dics_pkg::FRACTION_BITS_DEF,
   localparam int PROB_W        = FRACTION_BITS + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic signed [dics_pkg::VALUE_W-1:0] req_entry_value,
   input  logic [PROB_W-1:0]                req_entry_probability,
   input  logic                             req_last_entry,
   input  logic [PROB_W-1:0]                req_query_value,
   output dics_pkg::cmd_ctl_type            cmd_ctl,
   output logic [dics_pkg::VALUE_W-1:0]     cmd_value,
   output logic [PROB_W-1:0]                cmd_frac,
   input  logic                             cmd_pop
);

   localparam int QPTR_W = (dics_pkg::QUEUE_DEPTH > 1) ? $clog2(dics_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(dics_pkg::QUEUE_DEPTH + 1);
   localparam logic [PROB_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   dics_pkg::cmd_kind_type           kind_q  [dics_pkg::QUEUE_DEPTH];
   logic                             last_q  [dics_pkg::QUEUE_DEPTH];
   logic [dics_pkg::VALUE_W-1:0]     value_q [dics_pkg::QUEUE_DEPTH];
   logic [PROB_W-1:0]                frac_q  [dics_pkg::QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;
   dics_pkg::cmd_kind_type new_kind;
   logic [PROB_W-1:0]      new_frac;

   always_comb begin
      if (req_operation == dics_pkg::OP_LOAD) begin
         new_kind = dics_pkg::CMD_LOAD;
         new_frac = req_entry_probability;
      end else begin
         new_kind = (req_query_value > ONE) ? dics_pkg::CMD_RANGE : dics_pkg::CMD_QUERY;
         new_frac = req_query_value;
      end
   end

   assign busy = (count_ff == QCNT_W'(dics_pkg::QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = cmd_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(dics_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(dics_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_q[wr_ptr_ff]  <= new_kind;
         last_q[wr_ptr_ff]  <= req_last_entry;
         value_q[wr_ptr_ff] <= req_entry_value;
         frac_q[wr_ptr_ff]  <= new_frac;
      end
   end

   assign cmd_ctl.valid = (count_ff != '0);
   assign cmd_ctl.kind  = kind_q[rd_ptr_ff];
   assign cmd_ctl.last  = last_q[rd_ptr_ff];
   assign cmd_value     = value_q[rd_ptr_ff];
   assign cmd_frac      = frac_q[rd_ptr_ff];

endmodule

@@ design/dics_back.sv @@
// dics_back: table memories, load bookkeeping and binary search over the cumulative table
// depends on dics_pkg; fed by dics_front
module dics_back #(
   parameter int  MAX_ENTRIES   = dics_pkg::MAX_ENTRIES_DEF,
   parameter int  FRACTION_BITS = dics_pkg::FRACTION_BITS_DEF,
   localparam int PROB_W        = FRACTION_BITS + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dics_pkg::cmd_ctl_type                cmd_ctl,
   input  logic [dics_pkg::VALUE_W-1:0]         cmd_value,
   input  logic [PROB_W-1:0]                    cmd_frac,
   output logic                                 cmd_pop,
   input  logic [PROB_W-1:0]                    tolerance,
   output logic                                 rsp_strobe,
   output logic signed [dics_pkg::VALUE_W-1:0]  rsp_sampled_value,
   output logic [dics_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int TOT_W = PROB_W + IDX_W;
   localparam logic [PROB_W-1:0] ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [PROB_W-1:0] PROB_MAX = '1;

   logic [dics_pkg::VALUE_W-1:0] value_mem [MAX_ENTRIES];
   logic [PROB_W-1:0]            cum_mem   [MAX_ENTRIES];

   dics_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic              ready_ff, ready_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [PROB_W-1:0] u_ff, u_in;
   logic [PROB_W-1:0] cum_rd_ff;
   logic [dics_pkg::VALUE_W-1:0] val_rd_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [dics_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   dics_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [PROB_W-1:0] wr_cum;

   // load arithmetic
   logic [CNT_W-1:0]  eff_count;
   logic [TOT_W-1:0]  eff_total, load_sum, dev;
   logic [PROB_W-1:0] cum_sat;
   logic              full, sum_pass;

   // search step
   logic [CNT_W-1:0]  count_m1;
   logic [IDX_W-1:0]  last_idx, lo_step, hi_step, mid_step;
   logic [IDX_W:0]    mid_sum;
   logic              ge;

   assign eff_count = ready_ff ? '0 : count_ff;
   assign eff_total = ready_ff ? '0 : total_ff;
   assign full      = (eff_count >= CNT_W'(MAX_ENTRIES));
   assign load_sum  = eff_total + TOT_W'(cmd_frac);
   assign cum_sat   = (load_sum > TOT_W'(PROB_MAX)) ? PROB_MAX : load_sum[PROB_W-1:0];
   assign dev       = (load_sum >= TOT_W'(ONE)) ? load_sum - TOT_W'(ONE)
                                                : TOT_W'(ONE) - load_sum;
   assign sum_pass  = (dev < TOT_W'(tolerance));
   assign wr_cum    = (cmd_ctl.last && sum_pass) ? ONE : cum_sat;

   assign count_m1  = count_ff - 1'b1;
   assign last_idx  = count_m1[IDX_W-1:0];
   assign ge        = (cum_rd_ff >= u_ff);
   assign lo_step   = ge ? lo_ff : mid_ff + 1'b1;
   assign hi_step   = ge ? mid_ff : hi_ff;
   assign mid_sum   = {1'b0, lo_step} + {1'b0, hi_step};
   assign mid_step  = mid_sum[IDX_W:1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dics_pkg::BK_IDLE: begin
            if (cmd_ctl.valid && cmd_ctl.kind == dics_pkg::CMD_QUERY && ready_ff) begin
               state_in = (last_idx == '0) ? dics_pkg::BK_OUT : dics_pkg::BK_SEARCH;
            end
         end
         dics_pkg::BK_SEARCH: begin
            if (!(lo_step < hi_step)) begin
               state_in = dics_pkg::BK_OUT;
            end
         end
         dics_pkg::BK_OUT: state_in = dics_pkg::BK_IDLE;
         default:          state_in = dics_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      total_in      = total_ff;
      ready_in      = ready_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      u_in          = u_ff;
      rd_addr       = mid_ff;
      wr_en         = 1'b0;
      cmd_pop       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = dics_pkg::ST_OK;
      case (state_ff)
         dics_pkg::BK_IDLE: begin
            if (cmd_ctl.valid) begin
               cmd_pop = 1'b1;
               if (cmd_ctl.kind == dics_pkg::CMD_LOAD) begin
                  rsp_strobe_in = 1'b1;
                  ready_in      = 1'b0;
                  if (full) begin
                     rsp_status_in = dics_pkg::ST_FULL;
                     count_in      = cmd_ctl.last ? '0 : eff_count;
                     total_in      = cmd_ctl.last ? '0 : eff_total;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = eff_count + 1'b1;
                     total_in = load_sum;
                     if (cmd_ctl.last) begin
                        if (sum_pass) begin
                           ready_in = 1'b1;
                        end else begin
                           count_in      = '0;
                           total_in      = '0;
                           rsp_status_in = dics_pkg::ST_SUMFAIL;
                        end
                     end
                  end
               end else if (!ready_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dics_pkg::ST_EMPTY;
               end else if (cmd_ctl.kind != dics_pkg::CMD_QUERY) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dics_pkg::ST_RANGE;
               end else begin
                  u_in   = cmd_frac;
                  lo_in  = '0;
                  hi_in  = last_idx;
                  mid_in = last_idx >> 1;
                  rd_addr = last_idx >> 1;
               end
            end
         end
         dics_pkg::BK_SEARCH: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (lo_step < hi_step) begin
               mid_in  = mid_step;
               rd_addr = mid_step;
            end else begin
               mid_in  = lo_step;
               rd_addr = lo_step;
            end
         end
         dics_pkg::BK_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = val_rd_ff;
            rsp_status_in = dics_pkg::ST_OK;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dics_pkg::BK_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         ready_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         ready_ff      <= ready_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      u_ff          <= u_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[eff_count[IDX_W-1:0]] <= cmd_value;
         cum_mem[eff_count[IDX_W-1:0]]   <= wr_cum;
      end
      cum_rd_ff <= cum_mem[rd_addr];
      val_rd_ff <= value_mem[rd_addr];
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_sampled_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;

   a_ready_has_entries: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> count_ff != '0)
      else $error("ready table with no entries");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == dics_pkg::BK_SEARCH |-> lo_ff < hi_ff)
      else $error("search window collapsed while searching");

   a_out_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == dics_pkg::BK_OUT |=> rsp_strobe_ff && state_ff == dics_pkg::BK_IDLE)
      else $error("query result not delivered after search");

endmodule

@@ design/discrete_inverse_cdf_sampler.sv @@
// discrete_inverse_cdf_sampler: top level, tolerance register, front end and back end
// depends on dics_pkg, dics_front, dics_back
//
// usage
//   a transaction is taken at a rising edge with start high and busy low;
//   req_operation low loads one table entry (req_entry_value, req_entry_probability,
//   req_last_entry), high queries with req_query_value (unsigned q1.FRACTION_BITS)
//   every transaction gives exactly one result, shown for one cycle with rsp_strobe
//   high on rsp_sampled_value and rsp_status; results come out in transaction order
//   the receiver cannot stall: each result must be taken in its strobe cycle
//   csr_write_enable writes csr_write_data into the sum tolerance (reset value 7);
//   write it only while no transaction is outstanding
//   a two-entry queue sits between the front end and the back end; busy is high
//   while the queue is full
//   a load, a query on an empty table and an out-of-range query answer from the queue
//   through the registered response; a query steps the binary search through the
//   registered read port of the cumulative memory, then reads the selected value;
//   loads sustain one per cycle while no query search holds the back end
//   reset empties the table; stored entries need no clearing pass
module discrete_inverse_cdf_sampler #(
   parameter int  MAX_ENTRIES   = dics_pkg::MAX_ENTRIES_DEF,
   parameter int  FRACTION_BITS = dics_pkg::FRACTION_BITS_DEF,
   localparam int PROB_W        = FRACTION_BITS + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic signed [dics_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic [PROB_W-1:0]                    req_entry_probability,
   input  logic                                 req_last_entry,
   input  logic [PROB_W-1:0]                    req_query_value,
   output logic                                 rsp_strobe,
   output logic signed [dics_pkg::VALUE_W-1:0]  rsp_sampled_value,
   output logic [dics_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [PROB_W-1:0]                    csr_write_data
);

   logic [PROB_W-1:0] tol_ff, tol_in;

   dics_pkg::cmd_ctl_type        cmd_ctl;
   logic [dics_pkg::VALUE_W-1:0] cmd_value;
   logic [PROB_W-1:0]            cmd_frac;
   logic                         cmd_pop;

   assign tol_in = csr_write_enable ? csr_write_data : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= PROB_W'(dics_pkg::TOL_RESET);
      end else begin
         tol_ff <= tol_in;
      end
   end

   dics_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_entry_value      (req_entry_value),
      .req_entry_probability(req_entry_probability),
      .req_last_entry       (req_last_entry),
      .req_query_value      (req_query_value),
      .cmd_ctl              (cmd_ctl),
      .cmd_value            (cmd_value),
      .cmd_frac             (cmd_frac),
      .cmd_pop              (cmd_pop)
   );

   dics_back #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_ctl          (cmd_ctl),
      .cmd_value        (cmd_value),
      .cmd_frac         (cmd_frac),
      .cmd_pop          (cmd_pop),
      .tolerance        (tol_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_sampled_value(rsp_sampled_value),
      .rsp_status       (rsp_status)
   );

endmodule
